// ===== design/hfas_pkg.sv =====
// shared types and constants for the half float adder/subtractor
package hfas_pkg;

	localparam int WORD_W = 16;
	localparam int EXP_W = 5;
	localparam int FRAC_W = 10;
	localparam int SIG_W = FRAC_W + 2;
	localparam int SUM_W = SIG_W + 1;
	localparam int POS_W = 4;

	localparam logic [WORD_W-1:0] SIGN_MASK = 16'h8000;
	localparam logic [WORD_W-1:0] ZERO_WORD = 16'h0000;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_SUB = 1'b1
	} op_t;

	typedef struct packed {
		logic sign;
		logic [EXP_W-1:0] exp;
		logic [FRAC_W-1:0] frac;
	} half_t;

	// aligned sum, or a word to pass straight through
	typedef struct packed {
		logic bypass;
		logic [WORD_W-1:0] bypass_word;
		logic signed [SUM_W-1:0] sum;
		logic [EXP_W-1:0] exp;
	} align_t;

endpackage

// ===== design/hfas_align.sv =====
// operand unpack, zero bypass, exponent alignment and significand add
module hfas_align import hfas_pkg::*; (
	input  op_t              operation,
	input  logic [WORD_W-1:0] first_word,
	input  logic [WORD_W-1:0] second_word,
	output align_t           aligned
);

	half_t x, y;
	logic [WORD_W-1:0] y_word;
	logic signed [SIG_W-1:0] mx, my, mx_sh, my_sh;
	logic [EXP_W-1:0] diff;

	always_comb begin
		// subtract flips the sign, but zero stays zero
		if (operation == OP_SUB && second_word != ZERO_WORD) begin
			y_word = second_word ^ SIGN_MASK;
		end else begin
			y_word = second_word;
		end
		x = half_t'(first_word);
		y = half_t'(y_word);
	end

	always_comb begin
		mx = $signed({2'b01, x.frac});
		my = $signed({2'b01, y.frac});
		if (x.sign) begin
			mx = -mx;
		end
		if (y.sign) begin
			my = -my;
		end
	end

	always_comb begin
		mx_sh = mx;
		my_sh = my;
		if (x.exp > y.exp) begin
			diff = x.exp - y.exp;
			my_sh = my >>> diff;
			aligned.exp = x.exp;
		end else begin
			diff = y.exp - x.exp;
			mx_sh = mx >>> diff;
			aligned.exp = y.exp;
		end
		aligned.sum = {mx_sh[SIG_W-1], mx_sh} + {my_sh[SIG_W-1], my_sh};
		priority if (first_word == ZERO_WORD) begin
			aligned.bypass = 1'b1;
			aligned.bypass_word = y_word;
		end else if (y_word == ZERO_WORD) begin
			aligned.bypass = 1'b1;
			aligned.bypass_word = first_word;
		end else begin
			aligned.bypass = 1'b0;
			aligned.bypass_word = ZERO_WORD;
		end
	end

endmodule

// ===== design/hfas_norm.sv =====
// magnitude, leading-one normalize and pack of the aligned sum
module hfas_norm import hfas_pkg::*; (
	input  align_t           aligned,
	output logic [WORD_W-1:0] sum_word
);

	logic [SUM_W-1:0] abs_sum;
	logic [SIG_W-1:0] mag, mag_n;
	logic [POS_W-1:0] lead;
	logic [EXP_W-1:0] exp_n;
	logic sign;

	always_comb begin
		sign = aligned.sum[SUM_W-1];
		abs_sum = sign ? SUM_W'(-aligned.sum) : SUM_W'(aligned.sum);
		mag = abs_sum[SIG_W-1:0];
	end

	always_comb begin
		lead = '0;
		for (int i = 0; i < SIG_W; i++) begin
			if (mag[i]) begin
				lead = POS_W'(i);
			end
		end
	end

	always_comb begin
		if (lead > POS_W'(FRAC_W)) begin
			mag_n = mag >> (lead - POS_W'(FRAC_W));
		end else begin
			mag_n = mag << (POS_W'(FRAC_W) - lead);
		end
		// exponent wraps, only low bits are kept
		exp_n = aligned.exp + EXP_W'(lead) - EXP_W'(FRAC_W);
	end

	always_comb begin
		priority if (aligned.bypass) begin
			sum_word = aligned.bypass_word;
		end else if (aligned.sum == '0) begin
			sum_word = ZERO_WORD;
		end else begin
			sum_word = {sign, exp_n, mag_n[FRAC_W-1:0]};
		end
	end

endmodule

// ===== design/half_float_add_sub.sv =====
// half float add/subtract: input register, one combinational pass, result register
//
// Input channel: in_valid/in_ready with operation (0 add, 1 subtract),
// first_word and second_word, each 1 sign, 5 exponent, 10 fraction bits.
// Output channel: out_valid/out_ready with sum_word, truncated, no rounding.
// A zero operand passes the other one through; an exact cancel gives zero.
// No special handling of infinity, NaN, subnormals or exponent overflow.
//
// An accepted word is captured in the input register and moves on into the
// result register once that register is free; sum_word is registered.
// Throughput: one word per cycle while the receiver does not stall; align,
// add and normalize all sit in the single logic stage between the two registers.
// Reset (arst_n low) empties both registers; the block then accepts at once.
// When the receiver stalls, the result register holds and the input
// register still takes one more word; in_ready drops once both are full.
module half_float_add_sub import hfas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [WORD_W-1:0] first_word,
	input  logic [WORD_W-1:0] second_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] sum_word
);

	logic valid_s1, valid_s2;
	op_t op_s1;
	logic [WORD_W-1:0] x_s1, y_s1, sum_s2, sum_d;
	align_t aligned;
	logic adv_s1, in_fire;

	assign adv_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1 <= op_t'(operation);
			x_s1 <= first_word;
			y_s1 <= second_word;
		end
		if (adv_s1 && valid_s1) begin
			sum_s2 <= sum_d;
		end
	end

	hfas_align u_align (
		.operation   (op_s1),
		.first_word  (x_s1),
		.second_word (y_s1),
		.aligned     (aligned)
	);

	hfas_norm u_norm (
		.aligned  (aligned),
		.sum_word (sum_d)
	);

	assign out_valid = valid_s2;
	assign sum_word = sum_s2;

	// a held input word keeps its operands until the result stage frees up
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(x_s1) && $stable(y_s1))
		else $error("input stage lost a stalled word");

	// an accepted word always reaches the input register
	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted word not captured");

	// a word leaving the input stage lands in the result register
	a_move_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 |=> valid_s2 && sum_s2 == $past(sum_d))
		else $error("result register missed a word");

	// zero first operand passes the second one through; checked for add only
	a_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 && x_s1 == ZERO_WORD && op_s1 == OP_ADD
		|=> sum_s2 == $past(y_s1))
		else $error("zero operand bypass wrong");

endmodule
